FILE: design/kflh_pkg.sv
// ----------------------------------------------------------------------------
// kflh_pkg
// Shared types, constants and lookup functions for the keyed four-lane hash.
// ----------------------------------------------------------------------------
package kflh_pkg;

    localparam int LANE_COUNT = 4;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int BLOCK_BYTES = 32;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUND_W    = 4;

    typedef logic [LANE_COUNT-1:0][WORD_W-1:0] lane_vec_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_SIZE = 3'd4;

    localparam logic [1:0] SIZE_64  = 2'd0;
    localparam logic [1:0] SIZE_128 = 2'd1;

    localparam lane_vec_t KEY_RESET = {
        64'h1F1E1D1C1B1A1918, 64'h1716151413121110,
        64'h0F0E0D0C0B0A0908, 64'h0706050403020100
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS_A,
        ST_ABS_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step_a;
        logic step_b;
        logic fin;
        logic sum;
    } lane_ctrl_t;

    function automatic logic [WORD_W-1:0] init_a(input logic [1:0] idx);
        logic [WORD_W-1:0] r;
        unique case (idx)
            2'd0: r = 64'hdbe6d5d5fe4cce2f;
            2'd1: r = 64'ha4093822299f31d0;
            2'd2: r = 64'h13198a2e03707344;
            default: r = 64'h243f6a8885a308d3;
        endcase
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] init_b(input logic [1:0] idx);
        logic [WORD_W-1:0] r;
        unique case (idx)
            2'd0: r = 64'h3bd39e10cb0ef593;
            2'd1: r = 64'hc0acf169b5f18a8c;
            2'd2: r = 64'hbe5466cf34e90c6c;
            default: r = 64'h452821e638d01377;
        endcase
        return r;
    endfunction

    function automatic logic [ROUND_W-1:0] rounds_for(input logic [1:0] size);
        logic [ROUND_W-1:0] r;
        unique case (size)
            SIZE_64:  r = 4'd4;
            SIZE_128: r = 4'd6;
            default:  r = 4'd10;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] last_word_for(input logic [1:0] size);
        logic [1:0] r;
        unique case (size)
            SIZE_64:  r = 2'd0;
            SIZE_128: r = 2'd1;
            default:  r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

FILE: design/kflh_lane.sv
// ----------------------------------------------------------------------------
// kflh_lane
// One hash lane: v0/v1/mul0/mul1 state, 32x32 multiply mix, output pair sums.
// ----------------------------------------------------------------------------
module kflh_lane
    import kflh_pkg::*;
#(
    parameter int LANE_ID = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] key,
    input  logic [WORD_W-1:0] lane_in,
    input  logic [WORD_W-1:0] v0_merged,
    input  logic [WORD_W-1:0] v1_merged,
    output logic [WORD_W-1:0] v1,
    output logic [WORD_W-1:0] pair_a,
    output logic [WORD_W-1:0] pair_b
);

    localparam int ROT = 20 + LANE_ID;
    localparam logic [1:0] IDX = 2'(LANE_ID);

    logic [WORD_W-1:0] v0_reg, v1_reg, mul0_reg, mul1_reg;
    logic [HALF_W-1:0] hi_reg;
    logic [WORD_W-1:0] pa_reg, pb_reg;
    logic [WORD_W-1:0] lane_eff;
    logic [WORD_W-1:0] prod0, prod1;

    assign lane_eff = ctrl.fin ? (((v0_reg << ROT) | (v0_reg >> (WORD_W - ROT))) ^ v1_reg)
                               : lane_in;
    assign prod0 = v1_reg[HALF_W-1:0] * hi_reg;
    assign prod1 = v0_reg[HALF_W-1:0] * v1_reg[WORD_W-1:HALF_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= '0;
            v1_reg   <= '0;
            mul0_reg <= '0;
            mul1_reg <= '0;
        end
        else if (ctrl.load)
        begin
            mul0_reg <= init_a(IDX) ^ key;
            v0_reg   <= init_a(IDX) ^ key;
            mul1_reg <= init_b(IDX) ^ key;
            v1_reg   <= init_b(IDX) ^ key;
        end
        else if (ctrl.step_a)
        begin
            v1_reg <= v1_reg + mul0_reg + lane_eff;
            v0_reg <= v0_reg + mul1_reg;
        end
        else if (ctrl.step_b)
        begin
            mul0_reg <= mul0_reg ^ prod0;
            mul1_reg <= mul1_reg ^ prod1;
            v0_reg   <= v0_merged;
            v1_reg   <= v1_merged;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_a)
        begin
            hi_reg <= v0_reg[WORD_W-1:HALF_W];
        end
        if (ctrl.sum)
        begin
            pa_reg <= v0_reg + mul0_reg;
            pb_reg <= v1_reg + mul1_reg;
        end
    end

    assign v1     = v1_reg;
    assign pair_a = pa_reg;
    assign pair_b = pb_reg;

endmodule

FILE: design/kflh_merge.sv
// ----------------------------------------------------------------------------
// kflh_merge
// Pairwise-sum merge: rebuilds v0 from v1 pairs, then v1 from the new v0.
// ----------------------------------------------------------------------------
module kflh_merge
    import kflh_pkg::*;
(
    input  lane_vec_t v1,
    output lane_vec_t v0_merged,
    output lane_vec_t v1_merged
);

    logic [WORD_W-1:0] s0, s1;
    logic [HALF_W:0]   t0, t1;

    assign s0 = v1[0] + v1[1];
    assign s1 = v1[2] + v1[3];
    assign t0 = {1'b0, s0[HALF_W-1:0]} + {1'b0, s0[WORD_W-1:HALF_W]};
    assign t1 = {1'b0, s1[HALF_W-1:0]} + {1'b0, s1[WORD_W-1:HALF_W]};

    assign v0_merged[0] = {{HALF_W{1'b0}}, s0[HALF_W-1:0]};
    assign v0_merged[1] = {{HALF_W{1'b0}}, s0[WORD_W-1:HALF_W]};
    assign v0_merged[2] = {{HALF_W{1'b0}}, s1[HALF_W-1:0]};
    assign v0_merged[3] = {{HALF_W{1'b0}}, s1[WORD_W-1:HALF_W]};

    assign v1_merged[0] = {{HALF_W{1'b0}}, t0[HALF_W-1:0]};
    assign v1_merged[1] = {{(WORD_W-1){1'b0}}, t0[HALF_W]};
    assign v1_merged[2] = {{HALF_W{1'b0}}, t1[HALF_W-1:0]};
    assign v1_merged[3] = {{(WORD_W-1){1'b0}}, t1[HALF_W]};

endmodule

FILE: design/keyed_four_lane_hash.sv
// ----------------------------------------------------------------------------
// keyed_four_lane_hash
// Keyed four-lane block hash with 64/128/256-bit digest output.
//
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata block+count, tuser first, tlast last
// m_*      out  m_tvalid/m_tready    tdata digest word, tuser index, tlast
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A data block takes an add step, then a 32x32 multiply and merge step;
// a new beat can be taken during the merge step unless that beat was last.
// A last beat adds finalization rounds of both steps, a summing step,
// then one digest word per cycle, held while m_tready is low.
// Reset clears the lane state to zero and loads the default key; cfg is
// always ready; keys apply from the next first beat, size from the next beat.
// ----------------------------------------------------------------------------
module keyed_four_lane_hash
    import kflh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [263:0]         s_tdata,   // lane_word0..3, valid_bytes
    input  logic                 s_tuser,   // first_block
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // digest_word
    output logic [1:0]           m_tuser,   // word_index
    output logic                 m_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    state_t            state_reg, state_next;
    lane_vec_t         key_reg;
    logic [1:0]        size_cfg_reg;
    logic [1:0]        size_reg;
    logic              last_reg;
    logic [ROUND_W-1:0] round_reg;
    logic [1:0]        word_reg;
    lane_vec_t         block_reg;
    lane_vec_t         block_pad;

    logic [CNT_W-1:0]  n_raw, n_eff;
    logic              s_fire;
    logic              out_load;
    lane_ctrl_t        ctrl;

    lane_vec_t         v1, pa, pb, v0_merged, v1_merged;
    logic [WORD_W-1:0] word_sum;
    logic [1:0]        pb_idx;

    logic              m_tvalid_reg;
    logic [63:0]       m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              m_tlast_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) || ((state_reg == ST_ABS_B) && !last_reg);
    assign s_fire    = s_tvalid && s_tready;

    assign n_raw = s_tdata[4*WORD_W +: CNT_W];
    assign n_eff = (n_raw > 6'(BLOCK_BYTES)) ? 6'(BLOCK_BYTES) : n_raw;

    always_comb
    begin
        block_pad = '0;
        for (int b = 0; b < BLOCK_BYTES; b++)
        begin
            if (6'(b) < n_eff)
            begin
                block_pad[b/8][(b%8)*8 +: 8] = s_tdata[b*8 +: 8];
            end
        end
        if (n_eff != 6'(BLOCK_BYTES))
        begin
            block_pad[LANE_COUNT-1][WORD_W-8 +: 8] = {2'b00, n_eff};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= KEY_RESET;
            size_cfg_reg <= SIZE_64;
        end
        else if (cfg_valid)
        begin
            if (cfg_index < 3'(LANE_COUNT))
            begin
                key_reg[cfg_index[1:0]] <= cfg_data;
            end
            else if (cfg_index == CFG_DIGEST_SIZE)
            begin
                size_cfg_reg <= cfg_data[1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_ABS_B:
            begin
                if (s_fire)
                begin
                    if (n_eff != '0)
                    begin
                        state_next = ST_ABS_A;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_FIN_A;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (state_reg == ST_ABS_B)
                begin
                    state_next = last_reg ? ST_FIN_A : ST_IDLE;
                end
            end
            ST_ABS_A: state_next = ST_ABS_B;
            ST_FIN_A: state_next = ST_FIN_B;
            ST_FIN_B: state_next = (round_reg == 4'd1) ? ST_SUM : ST_FIN_A;
            ST_SUM:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_load && (word_reg == last_word_for(size_reg)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // lane control
    always_comb
    begin
        ctrl        = '0;
        ctrl.load   = s_fire && s_tuser;
        ctrl.step_a = (state_reg == ST_ABS_A) || (state_reg == ST_FIN_A);
        ctrl.fin    = (state_reg == ST_FIN_A);
        ctrl.step_b = (state_reg == ST_ABS_B) || (state_reg == ST_FIN_B);
        ctrl.sum    = (state_reg == ST_SUM);
    end

    assign out_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            size_reg  <= SIZE_64;
            round_reg <= '0;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_fire)
            begin
                last_reg  <= s_tlast;
                size_reg  <= size_cfg_reg;
                round_reg <= rounds_for(size_cfg_reg);
            end
            else if (state_reg == ST_FIN_B)
            begin
                round_reg <= round_reg - 4'd1;
            end
            if (state_reg == ST_SUM)
            begin
                word_reg <= '0;
            end
            else if (out_load)
            begin
                word_reg <= word_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            block_reg <= block_pad;
        end
    end

    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        kflh_lane #(
            .LANE_ID (i)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .key       (key_reg[i]),
            .lane_in   (block_reg[i]),
            .v0_merged (v0_merged[i]),
            .v1_merged (v1_merged[i]),
            .v1        (v1[i]),
            .pair_a    (pa[i]),
            .pair_b    (pb[i])
        );
    end

    kflh_merge u_merge (
        .v1        (v1),
        .v0_merged (v0_merged),
        .v1_merged (v1_merged)
    );

    // 128-bit digest crosses lanes: word k pairs lane k with lane k+2
    assign pb_idx   = (size_reg == SIZE_128) ? (word_reg + 2'd2) : word_reg;
    assign word_sum = pa[word_reg] + pb[pb_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_tdata_reg <= word_sum;
            m_tuser_reg <= word_reg;
            m_tlast_reg <= (word_reg == last_word_for(size_reg));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
